@@ design/assert_macros.svh @@
// assertion macros used by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rsr_pkg.sv @@
// ----------------------------------------------------------------------------
// rsr_pkg
// shared types and codes of the replacement selection run former
// ----------------------------------------------------------------------------
package rsr_pkg;

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam logic [2:0] ADDR_LIMIT = 3'd0;
    localparam logic [2:0] ADDR_DESC  = 3'd4;

    localparam logic [6:0] LIMIT_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TOP,
        S_MOVE
    } t_state;

endpackage

@@ design/rsr_ram.sv @@
// ----------------------------------------------------------------------------
// rsr_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module rsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/replacement_selection_runs.sv @@
// ----------------------------------------------------------------------------
// replacement_selection_runs
// forms sorted runs of an external sort by replacement selection
// ----------------------------------------------------------------------------
// Records are held in one memory of RESERVOIR_DEPTH entries. A push is written
// as it is taken; when the held count reaches the limit, the least record is
// found by streaming every held entry through the memory read port (one
// entry a cycle), then the last entry is read and moved into the freed slot.
// A push that gives out a record keeps the input busy until that record is
// popped, and a drain keeps it busy until every held record has gone; a
// stalled output holds the pop until the output register frees. Run tags
// are kept as the run number of each entry, so a run change needs no pass
// over the memory. No clearing pass is needed after reset.
module replacement_selection_runs #(
    parameter int RESERVOIR_DEPTH = 64,
    parameter int KEY_BITS        = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sort_key
    input  logic        s_axis_tuser,   // [0] func
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [31:0] out_key, [63:32] arrival_index,
                                        // [79:64] run_number
    output logic        m_axis_tuser,   // [0] starts_run
    output logic        m_axis_tlast,   // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    localparam int AW = $clog2(RESERVOIR_DEPTH);
    localparam int CW = $clog2(RESERVOIR_DEPTH + 1);
    localparam int EW = 16 + 32 + KEY_BITS;

    // configuration
    logic [6:0] r_limit;
    logic       r_desc;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= rsr_pkg::LIMIT_RESET;
            r_desc  <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr == rsr_pkg::ADDR_LIMIT) begin
                r_limit <= pwdata[6:0];
            end
            if (paddr == rsr_pkg::ADDR_DESC) begin
                r_desc <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == rsr_pkg::ADDR_LIMIT) begin
            prdata = {25'd0, r_limit};
        end else if (paddr == rsr_pkg::ADDR_DESC) begin
            prdata = {31'd0, r_desc};
        end
    end

    // state
    rsr_pkg::t_state r_state, n_state;
    logic [CW-1:0]       r_held, n_held;
    logic [15:0]         r_run, n_run;
    logic [KEY_BITS-1:0] r_last_key, n_last_key;
    logic                r_last_valid, n_last_valid;
    logic [31:0]         r_arrival, n_arrival;
    logic                r_drain, n_drain;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pend_idx, n_pend_idx;
    logic [AW-1:0]       r_m, n_m;
    logic [EW-1:0]       r_best, n_best;

    logic                r_out_valid, n_out_valid;
    logic [31:0]         r_out_key, n_out_key;
    logic [31:0]         r_out_arr, n_out_arr;
    logic [15:0]         r_out_run, n_out_run;
    logic                r_out_starts, n_out_starts;
    logic                r_out_last, n_out_last;

    // memory
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    rsr_ram #(
        .WIDTH (EW),
        .DEPTH (RESERVOIR_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // entry layout: {run, arrival, key}
    logic [KEY_BITS-1:0] rd_key, best_key, rd_ok, best_ok, in_key, in_ok, last_ok;
    logic [31:0]         rd_arr, best_arr;
    logic [15:0]         rd_run, best_run;
    logic                rd_tag, best_tag, rd_less;

    assign rd_key   = mem_rdata[KEY_BITS-1:0];
    assign rd_arr   = mem_rdata[KEY_BITS+31:KEY_BITS];
    assign rd_run   = mem_rdata[EW-1:KEY_BITS+32];
    assign best_key = r_best[KEY_BITS-1:0];
    assign best_arr = r_best[KEY_BITS+31:KEY_BITS];
    assign best_run = r_best[EW-1:KEY_BITS+32];
    // an entry whose run differs from the current one is tagged for the next
    assign rd_tag   = (rd_run != r_run);
    assign best_tag = (best_run != r_run);
    assign rd_ok    = r_desc ? ~rd_key : rd_key;
    assign best_ok  = r_desc ? ~best_key : best_key;
    assign in_key   = KEY_BITS'(s_axis_tdata);
    assign in_ok    = r_desc ? ~in_key : in_key;
    assign last_ok  = r_desc ? ~r_last_key : r_last_key;

    always_comb begin
        if (rd_tag != best_tag) begin
            rd_less = best_tag;
        end else if (rd_ok != best_ok) begin
            rd_less = rd_ok < best_ok;
        end else begin
            rd_less = rd_arr < best_arr;
        end
    end

    // effective limit, at least one and at most the depth
    int lim;
    always_comb begin
        lim = int'(r_limit);
        if (lim == 0) begin
            lim = 1;
        end
        if (lim > RESERVOIR_DEPTH) begin
            lim = RESERVOIR_DEPTH;
        end
    end

    logic in_fire, out_free, pop_fire;
    assign s_axis_tready = (r_state == rsr_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign pop_fire      = (r_state == rsr_pkg::S_MOVE) && out_free;

    logic [CW-1:0] top;
    assign top = r_held - CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsr_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser == rsr_pkg::FUNC_DRAIN) begin
                        if (r_held != '0) begin
                            n_state = rsr_pkg::S_SCAN;
                        end
                    end else if (int'(r_held) < RESERVOIR_DEPTH
                                 && int'(r_held) + 1 >= lim) begin
                        n_state = rsr_pkg::S_SCAN;
                    end
                end
            end
            rsr_pkg::S_SCAN: begin
                if (!r_pend && r_idx == r_held) begin
                    n_state = rsr_pkg::S_TOP;
                end
            end
            rsr_pkg::S_TOP: begin
                n_state = rsr_pkg::S_MOVE;
            end
            rsr_pkg::S_MOVE: begin
                if (out_free) begin
                    if (r_drain && top != '0) begin
                        n_state = rsr_pkg::S_SCAN;
                    end else begin
                        n_state = rsr_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = rsr_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_held       = r_held;
        n_run        = r_run;
        n_last_key   = r_last_key;
        n_last_valid = r_last_valid;
        n_arrival    = r_arrival;
        n_drain      = r_drain;
        n_idx        = r_idx;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_m          = r_m;
        n_best       = r_best;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_key    = r_out_key;
        n_out_arr    = r_out_arr;
        n_out_run    = r_out_run;
        n_out_starts = r_out_starts;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_waddr    = AW'(r_held);
        mem_wdata    = '0;
        mem_raddr    = AW'(r_idx);

        unique case (r_state)
            rsr_pkg::S_IDLE: begin
                n_idx = '0;
                if (in_fire) begin
                    if (s_axis_tuser == rsr_pkg::FUNC_DRAIN) begin
                        n_drain = 1'b1;
                        if (r_held == '0) begin
                            n_run        = 16'd1;
                            n_last_key   = '0;
                            n_last_valid = 1'b0;
                            n_arrival    = '0;
                            n_drain      = 1'b0;
                        end
                    end else if (int'(r_held) < RESERVOIR_DEPTH) begin
                        mem_we    = 1'b1;
                        mem_wdata = {(r_last_valid && in_ok < last_ok) ? r_run + 16'd1 : r_run,
                                     r_arrival, in_key};
                        n_arrival = r_arrival + 32'd1;
                        n_held    = r_held + CW'(1);
                    end
                end
            end
            rsr_pkg::S_SCAN: begin
                // reads issued one a cycle, compared as the data returns
                if (r_idx != r_held) begin
                    n_pend     = 1'b1;
                    n_pend_idx = AW'(r_idx);
                    n_idx      = r_idx + CW'(1);
                end
                if (r_pend && (r_pend_idx == '0 || rd_less)) begin
                    n_best = mem_rdata;
                    n_m    = r_pend_idx;
                end
            end
            rsr_pkg::S_TOP: begin
                mem_raddr = AW'(top);
            end
            rsr_pkg::S_MOVE: begin
                mem_raddr = AW'(top);
                n_idx     = '0;
                if (out_free) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_m;
                    mem_wdata = mem_rdata;
                    n_out_valid  = 1'b1;
                    n_out_key    = 32'(best_key);
                    n_out_arr    = best_arr;
                    n_out_last   = r_drain && (top == '0);
                    if (best_tag) begin
                        n_run        = r_run + 16'd1;
                        n_out_run    = r_run + 16'd1;
                        n_out_starts = 1'b1;
                    end else begin
                        n_out_run    = r_run;
                        n_out_starts = !r_last_valid;
                    end
                    n_last_key   = best_key;
                    n_last_valid = 1'b1;
                    n_held       = top;
                    if (r_drain && top == '0) begin
                        n_run        = 16'd1;
                        n_last_key   = '0;
                        n_last_valid = 1'b0;
                        n_arrival    = '0;
                        n_drain      = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rsr_pkg::S_IDLE;
            r_held       <= '0;
            r_run        <= 16'd1;
            r_last_key   <= '0;
            r_last_valid <= 1'b0;
            r_arrival    <= '0;
            r_drain      <= 1'b0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held       <= n_held;
            r_run        <= n_run;
            r_last_key   <= n_last_key;
            r_last_valid <= n_last_valid;
            r_arrival    <= n_arrival;
            r_drain      <= n_drain;
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx   <= n_pend_idx;
        r_m          <= n_m;
        r_best       <= n_best;
        r_out_key    <= n_out_key;
        r_out_arr    <= n_out_arr;
        r_out_run    <= n_out_run;
        r_out_starts <= n_out_starts;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_run, r_out_arr, r_out_key};
    assign m_axis_tuser  = r_out_starts;
    assign m_axis_tlast  = r_out_last;

    `ASSERT_ALWAYS(a_held_bound, i_clk, i_rst_n, int'(r_held) <= RESERVOIR_DEPTH,
        "held count above depth")
    `ASSERT_ALWAYS(a_move_in_range, i_clk, i_rst_n,
        !pop_fire || (r_held != '0 && CW'(r_m) < r_held), "freed slot outside held entries")
    `ASSERT_NEXT(a_pop_loads_out, i_clk, i_rst_n, pop_fire, r_out_valid,
        "popped record not presented")

endmodule
